// ===== hw/rtl/vic_pkg.sv =====
package vic_pkg;

	// fixed formats
	localparam int DAC_BITS   = 12;
	localparam int COORD_BITS = 16;
	localparam int SHR        = COORD_BITS - 12;

	// divider sizing: quotients stay below 2^QUO_W
	localparam int NUM_W = 60;
	localparam int DEN_W = 56;
	localparam int QUO_W = 21;

	localparam logic [DAC_BITS-1:0] DAC_MAX = '1;

	// sine polynomial, odd terms of a quarter wave
	localparam logic signed [31:0] SIN_PA9 = 32'sd43068;
	localparam logic signed [31:0] SIN_COEF [4] = '{
		-32'sd1256749, 32'sd21392327, -32'sd173399667, 32'sd421657428
	};

	typedef enum logic [1:0] {
		REQ_SYNC   = 2'd0,
		REQ_LINE   = 2'd1,
		REQ_CIRCLE = 2'd2,
		REQ_NONE   = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		CFG_X_SCALE      = 2'd0,
		CFG_Y_SCALE      = 2'd1,
		CFG_POINT_SETTLE = 2'd2,
		CFG_LOCK_SETTLE  = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [15:0] x_scale;
		logic [15:0] y_scale;
		logic [15:0] point_settle_us;
		logic [15:0] lock_settle_us;
	} cfg_t;

	// classified primitive between front and back
	typedef struct packed {
		req_kind_t          kind;
		logic signed [15:0] xs;
		logic signed [15:0] ys;
		logic signed [15:0] xe;
		logic signed [15:0] ye;
		logic signed [17:0] sy;
		logic [14:0]        radius;
		logic [15:0]        intensity;
	} cmd_t;

	// Q.12 coordinate to dac code, rounded and clamped
	function automatic logic [DAC_BITS-1:0] dac_map(input logic signed [23:0] c);
		logic [11:0]          off;
		logic [DAC_BITS+11:0] v;
		logic [DAC_BITS-1:0]  r;
		off = 12'(c + 24'sd2048);
		v = (DAC_BITS+12)'(off) * (DAC_BITS+12)'(DAC_MAX) + (DAC_BITS+12)'(2048);
		r = v[DAC_BITS+11:12];
		if (c <= -24'sd2048) r = '0;
		else if (c >= 24'sd2048) r = DAC_MAX;
		return r;
	endfunction

endpackage

// ===== hw/rtl/vic_req_if.sv =====
interface vic_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [15:0] x_start;
	logic [15:0] y_start;
	logic [15:0] x_end;
	logic [15:0] y_end;
	logic [14:0] radius;
	logic [15:0] intensity;

	modport source (output valid, req_type, x_start, y_start, x_end, y_end, radius,
		intensity, input ready);
	modport sink (input valid, req_type, x_start, y_start, x_end, y_end, radius,
		intensity, output ready);
endinterface

// ===== hw/rtl/vic_smp_if.sv =====
interface vic_smp_if import vic_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                integrator_reset;
	logic [DAC_BITS-1:0] dac_x;
	logic [DAC_BITS-1:0] dac_y;
	logic                dac_hold;
	logic [15:0]         wait_us;
	logic                last;

	modport source (output valid, integrator_reset, dac_x, dac_y, dac_hold, wait_us, last,
		input ready);
	modport sink (input valid, integrator_reset, dac_x, dac_y, dac_hold, wait_us, last,
		output ready);
endinterface

// ===== hw/rtl/vic_fifo.sv =====
module vic_fifo import vic_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wdata,
	output logic full,
	input  logic pop,
	output cmd_t rdata,
	output logic empty
);
	localparam int DEPTH = 2;

	cmd_t       mem_q [DEPTH];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	// entry storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign rdata = mem_q[rd_q];
	assign full  = (cnt_q == 2'(DEPTH));
	assign empty = (cnt_q == 2'd0);
endmodule

// ===== hw/rtl/vic_div.sv =====
module vic_div import vic_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic [QUO_W-1:0] quo
);
	localparam int CNT_W = $clog2(QUO_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [QUO_W-1:0] sh_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	// one quotient bit per cycle, restoring
	always_comb begin
		trial = {rem_q, sh_q[QUO_W-1]};
		fits  = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(QUO_W);
			rem_q  <= DEN_W'(num[NUM_W-1:QUO_W]);
			sh_q   <= num[QUO_W-1:0];
			den_q  <= den;
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			sh_q  <= {sh_q[QUO_W-2:0], fits};
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) busy_q <= 1'b0;
		end
	end

	assign busy = busy_q;
	assign quo  = sh_q;
endmodule

// ===== hw/rtl/vic_front.sv =====
module vic_front import vic_pkg::*; (
	vic_req_if.sink req,
	input  logic    full,
	output logic    push,
	output cmd_t    cmd
);
	req_kind_t kind;

	// classify the request, drop unknown types
	always_comb begin
		kind          = req_kind_t'(req.req_type);
		cmd.kind      = kind;
		cmd.xs        = req.x_start;
		cmd.ys        = req.y_start;
		cmd.xe        = req.x_end;
		cmd.ye        = req.y_end;
		cmd.radius    = req.radius;
		cmd.intensity = req.intensity;
		// circles sync at the top of the circle
		cmd.sy = (kind == REQ_CIRCLE) ? 18'($signed(req.y_start)) + 18'(req.radius)
			: 18'($signed(req.y_start));
	end

	assign req.ready = !full;
	assign push      = req.valid && !full && (kind != REQ_NONE);
endmodule

// ===== hw/rtl/vic_back.sv =====
module vic_back import vic_pkg::*; #(
	parameter int MAX_CIRCLE_STEPS = 62
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic empty,
	output logic pop,
	input  cmd_t cmd,
	vic_smp_if.source smp
);
	localparam int SW       = $clog2(MAX_CIRCLE_STEPS + 1);
	localparam int SQ_STEPS = 30;
	localparam logic [2:0] HORNER_LAST = 3'd4;

	typedef enum logic [4:0] {
		ST_IDLE, ST_STEP0, ST_STEP1, ST_SYM_X, ST_SYM_Y, ST_SYM_W, ST_SEM1, ST_SEM2,
		ST_PH, ST_PHW, ST_SNU, ST_SNW, ST_SNT, ST_SNM, ST_SNA, ST_PTM, ST_PTS,
		ST_CDX, ST_CDY, ST_CAY, ST_CSQ1, ST_CSQ2, ST_SQRT, ST_CLEN, ST_CDEN,
		ST_DVX, ST_DVXW, ST_DVY, ST_DVYW, ST_CEM, ST_CZ
	} state_t;

	state_t             state_q;
	cmd_t               cmd_q;
	logic signed [15:0] ref_x_q, ref_y_q;
	logic signed [17:0] px_q, py_q, nx_q, ny_q;
	logic [SW-1:0]      steps_q, i_q;
	logic               sync_last_q, chord_last_q;
	logic [63:0]        prod_q;
	logic [28:0]        ax_q, ay_q;
	logic               posx_q, posy_q;
	logic [59:0]        sum_q, sq_n_q, sq_r_q, sq_b_q;
	logic [4:0]         sq_cnt_q;
	logic [55:0]        den_q;
	logic [15:0]        wait_q;
	logic [QUO_W-1:0]   slx_q, sly_q;
	logic [16:0]        ph_q, u_q, w_q, s_q;
	logic               axis_q, sneg_q;
	logic signed [31:0] t_q;
	logic [2:0]         k_q;

	logic               ov_q, o_rst_q, o_hold_q, o_last_q;
	logic [DAC_BITS-1:0] o_dx_q, o_dy_q;
	logic [15:0]        o_wait_q;

	logic [31:0]        mul_a, mul_b;
	logic               out_free;
	logic signed [18:0] dx, dy;
	logic [18:0]        dx_mag, dy_mag;
	logic [17:0]        px_mag, py_mag;
	logic [31:0]        t_mag, pm;
	logic signed [31:0] mt, mt_rnd;
	logic [16:0]        s_next;
	logic [15:0]        p_cur;
	logic [16:0]        u_next;
	logic [16:0]        pt_v;
	logic signed [17:0] pt_coord;
	logic [38:0]        steps_raw;
	logic [14:0]        steps_full;
	logic [SW-1:0]      steps_next;
	logic [45:0]        li;
	logic [59:0]        wait_full;
	logic [59:0]        sq_rb;
	logic [34:0]        ax47, ay47;
	logic               div_start, div_busy;
	logic [NUM_W-1:0]   div_num;
	logic [DEN_W-1:0]   div_den;
	logic [QUO_W-1:0]   div_quo;
	logic signed [23:0] cx, cy;

	// rounded, saturated scaling of a coordinate magnitude
	function automatic logic signed [15:0] scale_ref(input logic neg, input logic [33:0] m);
		logic [20:0] rnd;
		logic [15:0] v;
		rnd = 21'((m + 34'd8192) >> 14);
		if (!neg && rnd > 21'd32767) v = 16'h7fff;
		else if (neg && rnd > 21'd32768) v = 16'h8000;
		else if (neg) v = 16'(~rnd + 21'd1);
		else v = 16'(rnd);
		return $signed(v);
	endfunction

	vic_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	// datapath helpers
	always_comb begin
		out_free = !ov_q || smp.ready;
		dx       = 19'(nx_q) - 19'(px_q);
		dy       = 19'(ny_q) - 19'(py_q);
		dx_mag   = dx[18] ? 19'(-dx) : 19'(dx);
		dy_mag   = dy[18] ? 19'(-dy) : 19'(dy);
		px_mag   = px_q[17] ? 18'(-px_q) : 18'(px_q);
		py_mag   = py_q[17] ? 18'(-py_q) : 18'(py_q);
		t_mag    = t_q[31] ? 32'(-t_q) : 32'(t_q);
		pm       = {1'b0, prod_q[46:16]};
		mt       = t_q[31] ? -$signed(pm) : $signed(pm);
		mt_rnd   = (mt + 32'sd2048) >>> 12;
		if (mt <= 32'sd0) s_next = '0;
		else if (mt_rnd > 32'sd65536) s_next = 17'd65536;
		else s_next = 17'(mt_rnd);
		p_cur    = axis_q ? 16'(ph_q + 17'd16384) : ph_q[15:0];
		u_next   = {1'b0, p_cur[13:0], 2'b00};
		if (p_cur[14]) u_next = 17'd65536 - u_next;
		pt_v     = 17'((prod_q[31:0] + 32'd32768) >> 16);
		pt_coord = 18'(axis_q ? cmd_q.ys : cmd_q.xs) + (sneg_q ? -18'(pt_v) : 18'(pt_v));
		steps_raw  = 39'(prod_q[30:0]) * 39'd100 + 39'(24'hffffff);
		steps_full = steps_raw[38:24];
		steps_next = (steps_full > 15'(MAX_CIRCLE_STEPS)) ? SW'(MAX_CIRCLE_STEPS)
			: SW'(steps_full);
		li        = prod_q[45:0];
		wait_full = 60'(li) * 60'd4500;
		sq_rb     = sq_r_q + sq_b_q;
		ax47      = 35'(ax_q) * 35'd47;
		ay47      = 35'(ay_q) * 35'd47;
		cx = 24'(ref_x_q) + (posx_q ? -24'(slx_q) : 24'(slx_q));
		cy = 24'(ref_y_q) + (posy_q ? -24'(sly_q) : 24'(sly_q));
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_STEP0: begin mul_a = 32'(cmd_q.radius); mul_b = 32'(cmd_q.intensity); end
			ST_SYM_X: begin mul_a = 32'(px_mag); mul_b = 32'(cfg.x_scale); end
			ST_SYM_Y: begin mul_a = 32'(py_mag); mul_b = 32'(cfg.y_scale); end
			ST_SNW:   begin mul_a = 32'(u_q); mul_b = 32'(u_q); end
			ST_SNM:   begin mul_a = t_mag; mul_b = 32'((k_q == HORNER_LAST) ? u_q : w_q); end
			ST_PTM:   begin mul_a = 32'(cmd_q.radius); mul_b = 32'(s_q); end
			ST_CDX:   begin mul_a = 32'(dx_mag); mul_b = 32'(cfg.x_scale); end
			ST_CDY:   begin mul_a = 32'(dy_mag); mul_b = 32'(cfg.y_scale); end
			ST_CAY:   begin mul_a = 32'(ax_q); mul_b = 32'(ax_q); end
			ST_CSQ1:  begin mul_a = 32'(ay_q); mul_b = 32'(ay_q); end
			ST_CLEN:  begin mul_a = 32'(sq_r_q[29:0]); mul_b = 32'(cmd_q.intensity); end
			default:  begin mul_a = '0; mul_b = '0; end
		endcase
	end

	// shared divider operand select
	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = den_q;
		case (state_q)
			ST_PH: begin
				div_start = 1'b1;
				div_num   = NUM_W'({i_q, 16'b0}) + NUM_W'(steps_q >> 1);
				div_den   = DEN_W'(steps_q);
			end
			ST_DVX: begin
				div_start = 1'b1;
				div_num   = NUM_W'({ax47, 24'b0}) + NUM_W'(den_q >> 1);
			end
			ST_DVY: begin
				div_start = 1'b1;
				div_num   = NUM_W'({ay47, 24'b0}) + NUM_W'(den_q >> 1);
			end
			default: div_start = 1'b0;
		endcase
	end

	assign pop = (state_q == ST_IDLE) && !empty;

	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q    <= 1'b0;
			ref_x_q <= '0;
			ref_y_q <= '0;
		end else begin
			if (smp.ready) ov_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						cmd_q        <= cmd;
						px_q         <= 18'(cmd.xs);
						py_q         <= cmd.sy;
						nx_q         <= 18'(cmd.xe);
						ny_q         <= 18'(cmd.ye);
						chord_last_q <= 1'b1;
						sync_last_q  <= 1'b1;
						case (cmd.kind)
							REQ_SYNC:   state_q <= ST_SYM_X;
							REQ_LINE:   state_q <= ST_CDX;
							REQ_CIRCLE: state_q <= ST_STEP0;
							default:    state_q <= ST_IDLE;
						endcase
					end
				end
				ST_STEP0: state_q <= ST_STEP1;
				ST_STEP1: begin
					steps_q     <= steps_next;
					sync_last_q <= (steps_next == '0);
					state_q     <= ST_SYM_X;
				end
				// sync: new reference, reset sample, hold sample
				ST_SYM_X: state_q <= ST_SYM_Y;
				ST_SYM_Y: begin
					ref_x_q <= scale_ref(px_q[17], prod_q[33:0]);
					state_q <= ST_SYM_W;
				end
				ST_SYM_W: begin
					ref_y_q <= scale_ref(py_q[17], prod_q[33:0]);
					state_q <= ST_SEM1;
				end
				ST_SEM1: begin
					if (out_free) begin
						ov_q     <= 1'b1;
						o_rst_q  <= 1'b1;
						o_dx_q   <= dac_map(24'(ref_x_q));
						o_dy_q   <= dac_map(24'(ref_y_q));
						o_hold_q <= 1'b0;
						o_wait_q <= cfg.point_settle_us;
						o_last_q <= 1'b0;
						state_q  <= ST_SEM2;
					end
				end
				ST_SEM2: begin
					if (out_free) begin
						ov_q     <= 1'b1;
						o_rst_q  <= 1'b0;
						o_dx_q   <= '0;
						o_dy_q   <= '0;
						o_hold_q <= 1'b1;
						o_wait_q <= cfg.lock_settle_us;
						o_last_q <= sync_last_q;
						if (cmd_q.kind == REQ_CIRCLE && !sync_last_q) begin
							i_q     <= SW'(1);
							state_q <= ST_PH;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				// circle point: phase, then sine for x and cosine for y
				ST_PH: state_q <= ST_PHW;
				ST_PHW: begin
					if (!div_busy) begin
						ph_q    <= div_quo[16:0];
						axis_q  <= 1'b0;
						state_q <= ST_SNU;
					end
				end
				ST_SNU: begin
					u_q     <= u_next;
					sneg_q  <= p_cur[15];
					state_q <= ST_SNW;
				end
				ST_SNW: state_q <= ST_SNT;
				ST_SNT: begin
					w_q     <= prod_q[32:16];
					t_q     <= SIN_PA9;
					k_q     <= '0;
					state_q <= ST_SNM;
				end
				ST_SNM: state_q <= ST_SNA;
				ST_SNA: begin
					if (k_q != HORNER_LAST) begin
						t_q     <= mt + SIN_COEF[k_q[1:0]];
						k_q     <= k_q + 3'd1;
						state_q <= ST_SNM;
					end else begin
						s_q     <= s_next;
						state_q <= ST_PTM;
					end
				end
				ST_PTM: state_q <= ST_PTS;
				ST_PTS: begin
					if (!axis_q) begin
						nx_q    <= pt_coord;
						axis_q  <= 1'b1;
						state_q <= ST_SNU;
					end else begin
						ny_q         <= pt_coord;
						chord_last_q <= (i_q == steps_q);
						state_q      <= ST_CDX;
					end
				end
				// chord: deltas, length, wait and slope terms
				ST_CDX: begin
					posx_q  <= !dx[18] && (dx != '0);
					posy_q  <= !dy[18] && (dy != '0);
					state_q <= ST_CDY;
				end
				ST_CDY: begin
					ax_q    <= prod_q[SHR+28:SHR];
					state_q <= ST_CAY;
				end
				ST_CAY: begin
					ay_q    <= prod_q[SHR+28:SHR];
					state_q <= ST_CSQ1;
				end
				ST_CSQ1: begin
					sum_q   <= prod_q[59:0];
					state_q <= ST_CSQ2;
				end
				ST_CSQ2: begin
					sq_n_q   <= sum_q + prod_q[59:0];
					sq_r_q   <= '0;
					sq_b_q   <= 60'(1) << 58;
					sq_cnt_q <= 5'(SQ_STEPS);
					state_q  <= ST_SQRT;
				end
				ST_SQRT: begin
					if (sq_n_q >= sq_rb) begin
						sq_n_q <= sq_n_q - sq_rb;
						sq_r_q <= (sq_r_q >> 1) + sq_b_q;
					end else begin
						sq_r_q <= sq_r_q >> 1;
					end
					sq_b_q   <= sq_b_q >> 2;
					sq_cnt_q <= sq_cnt_q - 5'd1;
					if (sq_cnt_q == 5'd1) state_q <= ST_CLEN;
				end
				ST_CLEN: begin
					if (sq_r_q[29:0] == '0 || cmd_q.intensity == '0) state_q <= ST_CZ;
					else state_q <= ST_CDEN;
				end
				ST_CDEN: begin
					den_q   <= 56'(li) * 56'd450;
					wait_q  <= (wait_full[59:34] > 26'hffff) ? 16'hffff : wait_full[49:34];
					state_q <= ST_DVX;
				end
				ST_DVX: state_q <= ST_DVXW;
				ST_DVXW: begin
					if (!div_busy) begin
						slx_q   <= div_quo;
						state_q <= ST_DVY;
					end
				end
				ST_DVY: state_q <= ST_DVYW;
				ST_DVYW: begin
					if (!div_busy) begin
						sly_q   <= div_quo;
						state_q <= ST_CEM;
					end
				end
				ST_CEM, ST_CZ: begin
					if (out_free) begin
						ov_q     <= 1'b1;
						o_rst_q  <= 1'b0;
						o_hold_q <= 1'b0;
						o_last_q <= chord_last_q;
						if (state_q == ST_CEM) begin
							o_dx_q   <= dac_map(cx);
							o_dy_q   <= dac_map(cy);
							o_wait_q <= wait_q;
						end else begin
							o_dx_q   <= dac_map(24'(ref_x_q));
							o_dy_q   <= dac_map(24'(ref_y_q));
							o_wait_q <= '0;
						end
						if (cmd_q.kind == REQ_CIRCLE && !chord_last_q) begin
							px_q    <= nx_q;
							py_q    <= ny_q;
							i_q     <= i_q + SW'(1);
							state_q <= ST_PH;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign smp.valid            = ov_q;
	assign smp.integrator_reset = o_rst_q;
	assign smp.dac_x            = o_dx_q;
	assign smp.dac_y            = o_dy_q;
	assign smp.dac_hold         = o_hold_q;
	assign smp.wait_us          = o_wait_q;
	assign smp.last             = o_last_q;
endmodule

// ===== hw/rtl/vector_integrator_sample_encoder_top.sv =====
// Vector display sample encoder: each request (sync point, line or circle) becomes
// integrator drive samples, the last one flagged. A two-entry queue sits between the
// request front end and the sample engine; finished samples wait in an output register
// while work goes on. A sync gives two samples; a line's time is set by the square
// root and the two slope divisions; a circle gives its sync and then its chords one
// after another, as the phase division, the sine and cosine polynomials and the chord
// math all share one multiplier and one divider.
// Unknown request types are accepted and dropped.
module vector_integrator_sample_encoder_top import vic_pkg::*; #(
	parameter int MAX_CIRCLE_STEPS = 62
) (
	input  logic        clk,
	input  logic        arst_n,
	vic_req_if.sink     req,
	vic_smp_if.source   smp,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);
	cfg_t cfg_q;
	logic push, pop, full, empty;
	cmd_t push_cmd, pop_cmd;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_scale         <= 16'd4096;
			cfg_q.y_scale         <= 16'd4096;
			cfg_q.point_settle_us <= 16'd50;
			cfg_q.lock_settle_us  <= 16'd4;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_X_SCALE:      cfg_q.x_scale         <= cfg_wdata;
				CFG_Y_SCALE:      cfg_q.y_scale         <= cfg_wdata;
				CFG_POINT_SETTLE: cfg_q.point_settle_us <= cfg_wdata;
				CFG_LOCK_SETTLE:  cfg_q.lock_settle_us  <= cfg_wdata;
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	vic_front u_front (
		.req  (req),
		.full (full),
		.push (push),
		.cmd  (push_cmd)
	);

	vic_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_cmd),
		.full   (full),
		.pop    (pop),
		.rdata  (pop_cmd),
		.empty  (empty)
	);

	vic_back #(
		.MAX_CIRCLE_STEPS (MAX_CIRCLE_STEPS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.empty  (empty),
		.pop    (pop),
		.cmd    (pop_cmd),
		.smp    (smp)
	);
endmodule
